@@ sv/ski_pkg.sv @@
// ----------------------------------------------------------------------------
// ski_pkg: shared types and constants for the keyframe interpolator
// Sizes, operation codes, sequencer states and the divider handshake structs.
// ----------------------------------------------------------------------------
package ski_pkg;

  localparam int unsigned SERVO_COUNT  = 12;
  localparam int unsigned MAX_FRAMES   = 16;
  localparam int unsigned MOTION_COUNT = 8;

  localparam int unsigned SERVO_W  = 4;
  localparam int unsigned MOTION_W = 3;
  localparam int unsigned FRAME_W  = 4;
  localparam int unsigned ANGLE_W  = 8;
  localparam int unsigned STEPS_W  = 16;
  localparam int unsigned FCNT_W   = 5;

  localparam int unsigned NUM_W   = ANGLE_W + STEPS_W;  // |diff| * count
  localparam int unsigned CNT_W   = $clog2(NUM_W + 1);
  localparam int unsigned ASLOT_W = $clog2(MOTION_COUNT * MAX_FRAMES * SERVO_COUNT);
  localparam int unsigned SSLOT_W = $clog2(MOTION_COUNT * MAX_FRAMES);

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_ANGLE  = 3'd1,
    OP_STEPS  = 3'd2,
    OP_FCOUNT = 3'd3,
    OP_SELECT = 3'd4,
    OP_POS    = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEPS,
    ST_FETCH,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [STEPS_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [NUM_W-1:0]  quot;
    logic              rem_nz;
  } div_rsp_t;

endpackage

@@ sv/ski_divider.sv @@
// ----------------------------------------------------------------------------
// ski_divider: restoring divider, one quotient bit per cycle
// Unsigned num / den with a flag for a nonzero remainder.
// ----------------------------------------------------------------------------
module ski_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ski_pkg::div_req_t req_i,
  output ski_pkg::div_rsp_t rsp_o
);
  import ski_pkg::*;

  logic [NUM_W-1:0]   quot_q, quot_d;
  logic [STEPS_W:0]   rem_q, rem_d;
  logic [STEPS_W-1:0] den_q, den_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [STEPS_W:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = '0;
    if (req_i.start) begin
      quot_d = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in the next numerator bit, subtract when it fits
      trial = {rem_q[STEPS_W-1:0], quot_q[NUM_W-1]};
      quot_d = {quot_q[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d     = trial - {1'b0, den_q};
        quot_d[0] = 1'b1;
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.quot   = quot_q;
  assign rsp_o.rem_nz = (rem_q != '0);

endmodule

@@ sv/servo_keyframe_interpolator_unit.sv @@
// ----------------------------------------------------------------------------
// servo_keyframe_interpolator_unit: looping keyframe player for servos
// Table writes, position sets, motion select and ticks that emit each
// servo's interpolated angle through one shared serial divider.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  in      | input     | in_valid/in_stall | operation motion keyframe servo
//          |           |                   | angle steps frame_count
//  out     | output    | out_valid/stall   | servo_index servo_angle last
//
// Non-tick transactions are carried out as they are accepted. After a tick is
// accepted, ST_STEPS and ST_FETCH do the step lookup; a tick that only
// advances the keyframe ends there. An emitting tick then takes each servo
// through angle fetch (ST_LOAD), division (ST_DIV, one quotient bit a cycle in
// the shared divider) and emit (ST_EMIT), longer while the output stalls. The
// input stall is high for the whole tick. Angle and step tables have no reset.
// ----------------------------------------------------------------------------
module servo_keyframe_interpolator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation_i,
  input  logic [2:0]  motion_i,
  input  logic [3:0]  keyframe_i,
  input  logic [3:0]  servo_i,
  input  logic [7:0]  angle_i,
  input  logic [15:0] steps_i,
  input  logic [4:0]  frame_count_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  servo_index_o,
  output logic [7:0]  servo_angle_o,
  output logic        last_o
);
  import ski_pkg::*;

  logic [ANGLE_W-1:0] angle_mem [MOTION_COUNT*MAX_FRAMES*SERVO_COUNT];
  logic [STEPS_W-1:0] steps_mem [MOTION_COUNT*MAX_FRAMES];
  logic [FCNT_W-1:0]  frames_q [MOTION_COUNT];
  logic [ANGLE_W-1:0] start_q [SERVO_COUNT];
  logic [ANGLE_W-1:0] pos_q [SERVO_COUNT];

  state_e              state_q, state_d;
  logic [MOTION_W-1:0] motion_q;
  logic [FRAME_W-1:0]  frame_q;
  logic [STEPS_W-1:0]  count_q;
  logic [STEPS_W-1:0]  steps_q;
  logic [SERVO_W-1:0]  sidx_q;
  logic                from_sel_q;   // 0: addressing target, 1: addressing source
  logic [1:0]          ld_ph_q;      // fetch phase within ST_LOAD
  logic [ANGLE_W-1:0]  rd_q, from_q;
  logic                neg_q;
  logic [ANGLE_W-1:0]  out_angle_q;
  logic                out_valid_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  ski_divider u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(div_req), .rsp_o(div_rsp));

  logic accept;
  assign in_stall = (state_q != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  function automatic logic [ASLOT_W-1:0] aslot(logic [MOTION_W-1:0] m,
                                                logic [FRAME_W-1:0] f,
                                                logic [SERVO_W-1:0] s);
    aslot = ASLOT_W'((32'(m) * MAX_FRAMES + 32'(f)) * SERVO_COUNT + 32'(s));
  endfunction

  // memory addressing
  logic [ASLOT_W-1:0] a_rd_addr;
  logic [SSLOT_W-1:0] s_rd_addr;
  logic [STEPS_W-1:0] steps_rd_q;
  always_comb begin
    if (from_sel_q)
      a_rd_addr = aslot(motion_q, frame_q - 1'b1, sidx_q);
    else
      a_rd_addr = aslot(motion_q, frame_q, sidx_q);
    s_rd_addr = SSLOT_W'(32'(motion_q) * MAX_FRAMES + 32'(frame_q));
  end

  always_ff @(posedge clk_i) begin
    if (accept && operation_i == OP_ANGLE && 32'(servo_i) < SERVO_COUNT)
      angle_mem[aslot(motion_i, keyframe_i, servo_i)] <= angle_i;
    rd_q <= angle_mem[a_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (accept && operation_i == OP_STEPS)
      steps_mem[SSLOT_W'(32'(motion_i) * MAX_FRAMES + 32'(keyframe_i))] <= steps_i;
    steps_rd_q <= steps_mem[s_rd_addr];
  end

  // divide magnitude; sign handled after. The target sits in rd_q in the
  // last fetch phase, the source in from_q.
  logic               diff_neg;
  logic [ANGLE_W-1:0] diff_mag;
  logic [NUM_W-1:0]   prod;
  assign diff_neg = rd_q < from_q;
  assign diff_mag = diff_neg ? (from_q - rd_q) : (rd_q - from_q);
  assign prod     = NUM_W'(diff_mag) * NUM_W'(count_q);

  // quotient fits 8 bits since count < steps
  logic [ANGLE_W-1:0] q8, res;
  assign q8  = div_rsp.quot[ANGLE_W-1:0] + ANGLE_W'(neg_q && div_rsp.rem_nz);
  assign res = neg_q ? (from_q - q8) : (from_q + q8);

  logic [FCNT_W-1:0] next_frame;
  assign next_frame = FCNT_W'(frame_q) + 1'b1;

  logic last_servo;
  assign last_servo = (32'(sidx_q) == SERVO_COUNT - 1);

  always_comb begin
    state_d       = state_q;
    div_req.start = 1'b0;
    div_req.num   = prod;
    div_req.den   = steps_q;
    case (state_q)
      ST_IDLE:  if (accept && operation_i == OP_TICK) state_d = ST_STEPS;
      ST_STEPS: state_d = ST_FETCH;
      ST_FETCH: begin
        if (!(count_q < steps_q)) state_d = ST_IDLE;
        else state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (ld_ph_q == 2'd2) begin
          state_d       = ST_DIV;
          div_req.start = 1'b1;
        end
      end
      ST_DIV:  if (div_rsp.done) state_d = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid_q || !out_stall) begin
          if (out_valid_q && last_o) state_d = ST_IDLE;
          else if (!out_valid_q) state_d = ST_EMIT;
        end
        if (out_valid_q && !out_stall && !last_o) state_d = ST_LOAD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      motion_q    <= '0;
      frame_q     <= '0;
      count_q     <= '0;
      sidx_q      <= '0;
      from_sel_q  <= 1'b0;
      ld_ph_q     <= '0;
      out_valid_q <= 1'b0;
      last_o      <= 1'b0;
      for (int i = 0; i < MOTION_COUNT; i++) frames_q[i] <= FCNT_W'(1);
      for (int i = 0; i < SERVO_COUNT; i++) begin
        start_q[i] <= '0;
        pos_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (operation_i)
              OP_FCOUNT: begin
                if (frame_count_i == '0) frames_q[motion_i] <= FCNT_W'(1);
                else if (32'(frame_count_i) > MAX_FRAMES)
                  frames_q[motion_i] <= FCNT_W'(MAX_FRAMES);
                else frames_q[motion_i] <= frame_count_i;
              end
              OP_SELECT: begin
                motion_q <= motion_i;
                frame_q  <= '0;
                count_q  <= '0;
              end
              OP_POS: if (32'(servo_i) < SERVO_COUNT) pos_q[servo_i] <= angle_i;
              OP_TICK: begin
                // snapshot positions at the first tick of keyframe 0
                if (frame_q == '0 && count_q == '0)
                  for (int i = 0; i < SERVO_COUNT; i++) start_q[i] <= pos_q[i];
              end
              default: ;
            endcase
          end
        end
        ST_FETCH: begin
          sidx_q     <= '0;
          from_sel_q <= (frame_q != '0);
          ld_ph_q    <= '0;
          if (!(count_q < steps_q)) begin
            count_q <= '0;
            if (next_frame >= frames_q[motion_q] || 32'(next_frame) >= MAX_FRAMES)
              frame_q <= '0;
            else
              frame_q <= FRAME_W'(next_frame);
          end
        end
        ST_LOAD: begin
          // phase 0 addresses the source, phases 1 and 2 the target
          from_sel_q <= 1'b0;
          if (ld_ph_q != 2'd2) ld_ph_q <= ld_ph_q + 1'b1;
        end
        ST_DIV: if (div_rsp.done) begin
          out_angle_q <= res;
          pos_q[sidx_q] <= res;
          out_valid_q <= 1'b1;
          last_o      <= last_servo;
        end
        ST_EMIT: if (out_valid_q && !out_stall) begin
          out_valid_q <= 1'b0;
          if (last_o) count_q <= count_q + 1'b1;
          else begin
            sidx_q     <= sidx_q + 1'b1;
            from_sel_q <= (frame_q != '0);
            ld_ph_q    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers; rd_q holds the word addressed in the previous cycle
  always_ff @(posedge clk_i) begin
    if (state_q == ST_STEPS) steps_q <= steps_rd_q;
    if (state_q == ST_LOAD && ld_ph_q == 2'd1)
      from_q <= (frame_q == '0) ? start_q[sidx_q] : rd_q;
    if (state_q == ST_LOAD && ld_ph_q == 2'd2) neg_q <= diff_neg;
  end

  assign out_valid     = out_valid_q;
  assign servo_index_o = sidx_q;
  assign servo_angle_o = out_angle_q;

endmodule
